/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with an asynchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/aip_pkg.sv */
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Shared types, character codes and the digit decoder.
// ----------------------------------------------------------------------------
package aip_pkg;

	typedef enum logic [2:0] {
		PH_SPACE   = 3'd0,
		PH_PREFIX  = 3'd1,
		PH_ZERO    = 3'd2,
		PH_DIGITS  = 3'd3,
		PH_STOPPED = 3'd4
	} phase_t;

	// Parser status reported to the top level.
	typedef struct packed {
		phase_t phase;
		logic   negative;
	} parse_status_t;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DIGIT0  = 8'h30;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	localparam logic [5:0] RADIX_AUTO = 6'd0;
	localparam logic [5:0] RADIX_BIN  = 6'd2;
	localparam logic [5:0] RADIX_OCT  = 6'd8;
	localparam logic [5:0] RADIX_DEC  = 6'd10;
	localparam logic [5:0] RADIX_HEX  = 6'd16;

	// Value of a digit or letter; 64 marks a character that is no digit.
	localparam logic [6:0] DIGIT_NONE = 7'd64;

	function automatic logic [6:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		d = 8'd64;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
		end else if (c inside {[8'h41:8'h5A]}) begin
			d = c - 8'h37;
		end else if (c inside {[8'h61:8'h7A]}) begin
			d = c - 8'h57;
		end
		return d[6:0];
	endfunction

endpackage

/* design/aip_parse.sv */
// ----------------------------------------------------------------------------
// ASCII integer parser state
// Holds the parse state and updates it by one character per enabled cycle.
// ----------------------------------------------------------------------------
module aip_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            char_in,
	input  logic [5:0]            radix_mode,
	output logic signed [31:0]    value,
	output aip_pkg::parse_status_t status
);
	import aip_pkg::*;

	phase_t      phase_q, phase_d;
	logic        neg_q, neg_d;
	logic [31:0] acc_q, acc_d;
	logic [5:0]  radix_q, radix_d;

	logic [6:0]  dval;
	logic        take_pfx;
	logic        do_digit;
	logic [31:0] prod;

	assign dval = digit_value(char_in);
	assign prod = acc_q * {26'b0, radix_d};

	// Result of the current string, valid when char_in is the terminator.
	assign value  = neg_q ? -$signed(acc_q) : $signed(acc_q);
	assign status = '{phase: phase_q, negative: neg_q};

	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		acc_d    = acc_q;
		radix_d  = radix_q;
		take_pfx = 1'b0;
		do_digit = 1'b0;

		case (phase_q)
			PH_SPACE: begin
				if (char_in == CH_SPACE || char_in == CH_TAB) begin
					phase_d = PH_SPACE;
				end else if (char_in == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_PREFIX;
				end else if (char_in == CH_PLUS) begin
					phase_d = PH_PREFIX;
				end else begin
					take_pfx = 1'b1;
				end
			end
			PH_PREFIX: begin
				take_pfx = 1'b1;
			end
			PH_ZERO: begin
				if (char_in == CH_PERCENT) begin
					radix_d = RADIX_BIN;
					phase_d = PH_DIGITS;
				end else if (char_in == CH_LOWER_X) begin
					radix_d = RADIX_HEX;
					phase_d = PH_DIGITS;
				end else begin
					radix_d  = RADIX_OCT;
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				do_digit = 1'b1;
			end
			default: begin
				phase_d = PH_STOPPED;
			end
		endcase

		// The first significant character picks the radix.
		if (take_pfx) begin
			if (radix_mode == RADIX_AUTO) begin
				if (char_in == CH_DIGIT0) begin
					phase_d = PH_ZERO;
				end else begin
					radix_d  = RADIX_DEC;
					do_digit = 1'b1;
				end
			end else begin
				radix_d  = radix_mode;
				do_digit = 1'b1;
			end
		end

		if (do_digit) begin
			if (dval >= {1'b0, radix_d}) begin
				phase_d = PH_STOPPED;
			end else begin
				acc_d   = prod + {25'b0, dval};
				phase_d = PH_DIGITS;
			end
		end

		// The terminator re-arms the parser for the next string.
		if (char_in == CH_NUL) begin
			phase_d = PH_SPACE;
			neg_d   = 1'b0;
			acc_d   = '0;
			radix_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			radix_q <= '0;
		end else if (en) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			acc_q   <= acc_d;
			radix_q <= radix_d;
		end
	end

endmodule

/* design/ascii_integer_parser.sv */
// ----------------------------------------------------------------------------
// ASCII integer parser
// Turns a zero-terminated character stream into signed 32-bit integers.
// ----------------------------------------------------------------------------
// The block takes one character per input beat and emits one signed result
// beat for each zero byte, which ends a string. Leading spaces and tabs are
// skipped and one optional '+' or '-' is taken. With radix_mode at zero the
// radix follows the prefix: "0x" is hexadecimal, "0%" is binary, any other
// leading zero is octal and anything else is decimal; a nonzero radix_mode
// is used as the fixed radix. Letters of either case count as digits ten and
// up. The first character that is not a digit of the radix freezes the
// value until the terminator, and the value wraps modulo 2^32. The block
// accepts one beat every clock cycle unless the input side stalls. A
// character waits in the input register and is folded into the accumulator
// by a single 32 by 6 bit multiply-add on the next edge. A terminator
// instead loads the output register as it leaves the input register, and
// the output register then presents its result beat. The input side stalls
// only when a terminator meets a result that the downstream side has not
// yet taken.
// radix_mode may be written only while no string is in flight; it takes
// effect at the first significant character of the next string.
module ascii_integer_parser (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: radix_mode
	input  logic               cfg_wen,
	input  logic [5:0]         cfg_wdata,
	// Character stream
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] character
	// Result stream
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic signed [31:0] m_tdata    // [31:0] value
);
	import aip_pkg::*;

	`include "assert_macros.svh"

	// Configuration register.
	logic [5:0] radix_mode_q;

	// Input stage: one character waiting to be folded in.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Output register.
	logic               out_valid_q;
	logic signed [31:0] out_data_q;

	logic               term_s1;
	logic               advance;
	logic               emit;
	logic signed [31:0] parse_value;
	parse_status_t      parse_status;

	assign term_s1 = (char_s1 == CH_NUL);

	// Only a terminator needs the output register; other characters always move on.
	assign advance  = !(valid_s1 && term_s1 && out_valid_q && !m_tready);
	assign emit     = valid_s1 && term_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_mode_q <= RADIX_AUTO;
		end else if (cfg_wen) begin
			radix_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	aip_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (valid_s1 && advance),
		.char_in    (char_s1),
		.radix_mode (radix_mode_q),
		.value      (parse_value),
		.status     (parse_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= parse_value;
		end
	end

	// A terminator never overwrites a result that is still waiting.
	`AST_IMPL(a_no_overwrite, clk, arst_n, valid_s1 && term_s1 && out_valid_q && !m_tready, !s_tready && !emit)
	// A consumed terminator always shows up as a result beat.
	`AST_NEXT(a_emit_result, clk, arst_n, emit, m_tvalid)
	// After a terminator the parser is back to skipping whitespace, sign cleared.
	`AST_NEXT(a_rearm, clk, arst_n, emit, parse_status.phase == PH_SPACE && !parse_status.negative)

endmodule

/* test/tb_ascii_integer_parser.sv */
// ----------------------------------------------------------------------------
// ASCII integer parser testbench
// Streams zero-terminated strings into the parser and checks every value.
// ----------------------------------------------------------------------------
// A scoreboard object runs its own version of the parser state machine on
// each accepted character beat. It queues the value that each terminator
// must produce, and it compares every accepted result beat with the oldest
// queued value. The stimulus begins with a short set of hand-written strings
// that hit the corner cases. Random strings then follow under a range of
// radix_mode settings. Most of them are well formed, and the rest is noise.
// Both stream sides idle at random under three profiles. Once, the receiver
// holds off for a long stretch so that the input side has to stall.
// ----------------------------------------------------------------------------
module tb_ascii_integer_parser;
	import aip_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned BLOCK_CHARS = 34;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned LONG_HOLD = 300;

	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	typedef logic [7:0] text_q_t[$];

	// ------------------------------------------------------------------------
	// Scoreboard: a parser model plus the queue of values still to come.
	// ------------------------------------------------------------------------
	class parse_scoreboard;
		phase_t      phase;
		logic        negative;
		logic [31:0] acc;
		logic [5:0]  radix_in_use;
		logic [5:0]  radix_mode;
		logic signed [31:0] expected_values[$];
		int unsigned mismatches;

		function new();
			radix_mode = RADIX_AUTO;
			mismatches = 0;
			clear_string();
		endfunction

		function void clear_string();
			phase = PH_SPACE;
			negative = 1'b0;
			acc = '0;
			radix_in_use = '0;
		endfunction

		function void set_radix_mode(input logic [5:0] m);
			radix_mode = m;
		endfunction

		function int unsigned pending();
			return expected_values.size();
		endfunction

		// Digits and letters of either case; anything else maps to 64.
		function logic [6:0] digit_of(input logic [7:0] ch);
			if (ch >= CH_DIGIT0 && ch <= CH_DIGIT0 + 8'd9) begin
				return 7'(ch - CH_DIGIT0);
			end
			if (ch >= CH_UPPER_A && ch <= CH_UPPER_A + 8'd25) begin
				return 7'(ch - CH_UPPER_A + 8'd10);
			end
			if (ch >= CH_LOWER_A && ch <= CH_LOWER_A + 8'd25) begin
				return 7'(ch - CH_LOWER_A + 8'd10);
			end
			return DIGIT_NONE;
		endfunction

		function void fold_digit(input logic [7:0] ch);
			logic [6:0] n;
			n = digit_of(ch);
			if (n >= {1'b0, radix_in_use}) begin
				phase = PH_STOPPED;
			end else begin
				acc = acc * 32'(radix_in_use) + 32'(n);
				phase = PH_DIGITS;
			end
		endfunction

		// First significant character: the radix is latched here.
		function void first_digit(input logic [7:0] ch);
			if (radix_mode == RADIX_AUTO) begin
				if (ch == CH_DIGIT0) begin
					phase = PH_ZERO;
					return;
				end
				radix_in_use = RADIX_DEC;
			end else begin
				radix_in_use = radix_mode;
			end
			fold_digit(ch);
		endfunction

		function void note_char(input logic [7:0] ch);
			if (ch == CH_NUL) begin
				expected_values.push_back(negative ? -acc : acc);
				clear_string();
				return;
			end
			case (phase)
				PH_SPACE: begin
					if (ch == CH_SPACE || ch == CH_TAB) begin
						phase = PH_SPACE;
					end else if (ch == CH_MINUS) begin
						negative = 1'b1;
						phase = PH_PREFIX;
					end else if (ch == CH_PLUS) begin
						phase = PH_PREFIX;
					end else begin
						first_digit(ch);
					end
				end
				PH_PREFIX: begin
					first_digit(ch);
				end
				PH_ZERO: begin
					if (ch == CH_PERCENT) begin
						radix_in_use = RADIX_BIN;
						phase = PH_DIGITS;
					end else if (ch == CH_LOWER_X) begin
						radix_in_use = RADIX_HEX;
						phase = PH_DIGITS;
					end else begin
						radix_in_use = RADIX_OCT;
						fold_digit(ch);
					end
				end
				PH_DIGITS: begin
					fold_digit(ch);
				end
				default: begin
					phase = PH_STOPPED;
				end
			endcase
		endfunction

		task report_mismatch(input string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_value(input logic signed [31:0] got);
			logic signed [31:0] want;
			if (expected_values.size() == 0) begin
				report_mismatch($sformatf("value %0d arrived with none outstanding", got));
			end else begin
				want = expected_values.pop_front();
				if (got !== want) begin
					report_mismatch($sformatf("value is %0d, should be %0d", got, want));
				end
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Signals and the block under test
	// ------------------------------------------------------------------------
	logic               clk;
	logic               arst_n;
	logic               cfg_wen;
	logic [5:0]         cfg_wdata;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // [7:0] character
	logic               m_tvalid;
	logic               m_tready;
	logic signed [31:0] m_tdata;   // [31:0] value

	parse_scoreboard sb;
	int unsigned     cycles;
	int unsigned     chars_sent;
	int unsigned     send_idle_pct;
	int unsigned     recv_idle_pct;
	logic            hold_req;

	ascii_integer_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run ends here if something hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side. The first time a long hold is requested, tready stays low
	// until a hold counter loaded from LONG_HOLD runs out; otherwise tready
	// drops with the current percentage.
	initial begin
		int unsigned hold_left;
		logic        hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_taken) begin
				hold_left = LONG_HOLD;
				hold_taken = 1'b1;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Every accepted result beat goes straight to the scoreboard. Outputs are
	// sampled at the edge before any register update of that edge lands.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_value(m_tdata);
		end
	end

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// One character beat. tvalid stays high after acceptance so that
	// back-to-back beats need no extra assignment. It only drops during a gap.
	task automatic send_char(input logic [7:0] ch);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.note_char(ch);
		chars_sent++;
	endtask

	task automatic send_text_q(input text_q_t s);
		foreach (s[i]) begin
			send_char(s[i]);
		end
	endtask

	// A string literal followed by its terminator.
	task automatic send_word(input string t);
		for (int i = 0; i < t.len(); i++) begin
			send_char(t[i]);
		end
		send_char(CH_NUL);
	endtask

	// Stops offering characters and lets every outstanding value come out.
	// The extra cycles cover a character that is still in the pipeline.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// radix_mode is only written with nothing in flight.
	task automatic write_radix(input logic [5:0] m);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		sb.set_radix_mode(m);
	endtask

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) begin
			return CH_DIGIT0 + 8'(d);
		end
		return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d - 10);
	endfunction

	// One random string with its terminator. Most strings are well formed:
	// optional blanks, optional sign, an auto-radix prefix when radix_mode is
	// zero, then digits valid for the radix with an occasional stray byte.
	// The rest are plain noise.
	function automatic text_q_t random_string(input logic [5:0] mode);
		logic [5:0]  auto_bases[4];
		text_q_t     s;
		logic [5:0]  base;
		int unsigned lim;
		int unsigned lo;
		int unsigned ndig;
		int unsigned sign_pick;
		auto_bases = '{RADIX_DEC, RADIX_OCT, RADIX_BIN, RADIX_HEX};
		if ($urandom_range(99) < 10) begin
			repeat ($urandom_range(8)) s.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(2)) s.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
			sign_pick = $urandom_range(2);
			if (sign_pick == 1) begin
				s.push_back(CH_MINUS);
			end else if (sign_pick == 2) begin
				s.push_back(CH_PLUS);
			end
			base = mode;
			lo = 0;
			if (mode == RADIX_AUTO) begin
				base = auto_bases[$urandom_range(3)];
				if (base == RADIX_DEC) begin
					// A leading zero would switch to octal.
					lo = 1;
				end else begin
					s.push_back(CH_DIGIT0);
					if (base == RADIX_BIN) begin
						s.push_back(CH_PERCENT);
					end else if (base == RADIX_HEX) begin
						s.push_back(CH_LOWER_X);
					end
				end
			end
			// Past 36 every digit and letter is valid.
			lim = (base > 36) ? 36 : base;
			ndig = $urandom_range(14);
			for (int i = 0; i < ndig; i++) begin
				if ($urandom_range(99) < 4) begin
					s.push_back(8'($urandom_range(1, 255)));
				end else begin
					s.push_back(digit_char($urandom_range(lim - 1, (i == 0) ? lo : 0)));
				end
			end
		end
		s.push_back(CH_NUL);
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [5:0]  modes[10];
		int unsigned target;
		sb = new();
		chars_sent = 0;
		send_idle_pct = 12;
		recv_idle_pct = 67;
		hold_req = 1'b0;
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Radix settings per block: automatic detection, the usual fixed
		// radices, radix one, the letter limit, the register maximum and one
		// random setting.
		modes = '{RADIX_AUTO, RADIX_DEC, RADIX_HEX, RADIX_BIN, 6'd1,
			6'd36, 6'd63, 6'($urandom_range(1, 63)), RADIX_AUTO, RADIX_OCT};

		write_radix(RADIX_AUTO);
		// Hand-written corner cases under automatic radix detection.
		send_word("");          // empty string
		send_word("\t+0%11");   // blanks, plus sign, binary prefix
		send_word("-0x");       // sign and hex prefix but no digits
		send_word("--7");       // second sign stops the parse
		send_word("- 5");       // blank after the sign stops the parse
		send_word("017");       // leading zero means octal
		send_word("0X1");       // upper-case X is no hex prefix
		send_text_q('{8'h39, 8'hFF, 8'h37, CH_NUL});   // high byte is invalid

		for (int b = 0; b < 10; b++) begin
			if (b == 4) begin
				send_idle_pct = 67;
				recv_idle_pct = 12;
			end else if (b == 7) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_radix(modes[b]);
			// With the sender running flat out, a long receiver hold fills the
			// result path and forces the character side to stall.
			if (b == 7) begin
				hold_req = 1'b1;
			end
			target = chars_sent + BLOCK_CHARS;
			while (chars_sent < target) begin
				send_text_q(random_string(modes[b]));
			end
		end

		drain();
		if (sb.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/aip_pkg.sv
design/aip_parse.sv
design/ascii_integer_parser.sv
test/tb_ascii_integer_parser.sv
